/* sv/rln_pkg.sv */
// ---------------------------------------------------------------------------
// rln_pkg: shared types and constants for the relative layout normalizer
// Item kinds, status codes, result kinds, register indices and the divider request and response.
// ---------------------------------------------------------------------------
`default_nettype none
package rln_pkg;
  localparam int DEPTH = 64;
  localparam int IDX_W = 6;

  localparam logic [1:0] KIND_RECT  = 2'd0;
  localparam logic [1:0] KIND_TEXT  = 2'd1;
  localparam logic [1:0] KIND_IMAGE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RECT = 2'd1;
  localparam logic [1:0] ST_NO_ELEM = 2'd2;

  localparam logic [1:0] EK_TEXT   = 2'd0;
  localparam logic [1:0] EK_IMAGE  = 2'd1;
  localparam logic [1:0] EK_BOUNDS = 2'd2;

  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_PH   = 3'd1;
  localparam logic [2:0] CFG_LX   = 3'd2;
  localparam logic [2:0] CFG_LY   = 3'd3;
  localparam logic [2:0] CFG_LW   = 3'd4;
  localparam logic [2:0] CFG_LH   = 3'd5;

  // numerator/denominator magnitudes fit in 28 bits
  localparam int NUM_W = 28;
  localparam int Q_W   = 17;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] q;
  } div_rsp_t;
endpackage
`default_nettype wire

/* sv/relative_layout_normalizer.sv */
// ---------------------------------------------------------------------------
// relative_layout_normalizer: page box collector and relative normalizer
// Collects boxes until last_item, picks bounds, emits normalized elements or one bounds result.
// ---------------------------------------------------------------------------
// Boxes are taken one per cycle while busy is low. After last_item the block
// picks the bounds and then emits one result per stored text, then per stored
// image, or a single bounds-only result when there is nothing to normalize.
// Each result needs four ratios from the single shared radix-2 divider, and
// store entries of the other kind are fetched and skipped on the way.
// Results appear on out_* for one cycle with out_valid high; the receiver
// cannot stall them.
`default_nettype none
module relative_layout_normalizer #(
  parameter int MAX_TEXTS  = 32,
  parameter int MAX_IMAGES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_item_kind,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic [22:0] in_size_w,
  input  wire logic [22:0] in_size_h,
  input  wire logic        in_last_item,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [1:0]       out_elem_kind,
  output logic signed [15:0] out_rel_center_x,
  output logic signed [15:0] out_rel_center_y,
  output logic signed [15:0] out_rel_width,
  output logic signed [15:0] out_rel_height,
  output logic signed [23:0] out_bounds_left,
  output logic signed [23:0] out_bounds_bottom,
  output logic [23:0]      out_bounds_width,
  output logic [23:0]      out_bounds_height,
  output logic             out_last_result
);
  import rln_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001, S_PICK = 7'b0000010, S_FETCH = 7'b0000100,
    S_READ = 7'b0001000, S_DIV  = 7'b0010000, S_EMIT  = 7'b0100000,
    S_ONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic        mode_r;
  logic [22:0] ph_r, lw_r, lh_r;
  logic signed [23:0] lx_r, ly_r;

  // page state
  logic [6:0] stored_r, tcnt_r, icnt_r;
  logic [45:0] rarea_r, iarea_r;
  logic signed [25:0] rx_r, ry_r, ix_r, iy_r;
  logic [22:0] rw_r, rh_r, iw_r, ih_r;
  logic signed [25:0] ux0_r, uy0_r, ux1_r, uy1_r;

  // store: x, y, w, h, image flag
  logic [94:0] mem [DEPTH];
  logic [94:0] rd_r;
  logic [IDX_W-1:0] wr_idx;

  // bounds
  logic signed [25:0] bx0_r, by0_r;
  logic signed [26:0] bw_r, bh_r;
  logic [1:0] st_r;

  logic [6:0] ptr_r, n_r;
  logic       pass_r;
  logic [1:0] step_r;
  logic [15:0] rel_r [4];
  logic       issue_r;

  div_req_t req;
  div_rsp_t rsp;

  rln_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  logic acc;
  logic [45:0] area;
  logic is_img, room;
  logic signed [25:0] in_x1, in_y1;
  assign acc   = start && !busy;
  assign area  = in_size_w * in_size_h;
  assign is_img = in_item_kind == KIND_IMAGE;
  assign room  = (stored_r < 7'(DEPTH)) &&
                 (is_img ? (icnt_r < 7'(MAX_IMAGES)) : (tcnt_r < 7'(MAX_TEXTS)));
  assign wr_idx = stored_r[IDX_W-1:0];
  assign busy  = state_r != S_LOAD;
  // far edges of the incoming box, signed
  assign in_x1 = 26'(in_pos_x) + $signed({3'b000, in_size_w});
  assign in_y1 = 26'(in_pos_y) + $signed({3'b000, in_size_h});

  // element fields from read data
  logic signed [25:0] ex, ey;
  logic [22:0] ew, eh;
  logic        eimg;
  assign ex   = 26'(signed'(rd_r[94:71]));
  assign ey   = 26'(signed'(rd_r[70:47]));
  assign ew   = rd_r[46:24];
  assign eh   = rd_r[23:1];
  assign eimg = rd_r[0];

  // numerators for the four ratios
  logic signed [28:0] nsg;
  logic [NUM_W-1:0] dmag;
  always_comb begin
    unique case (step_r)
      2'd0: begin
        nsg  = 29'(2 * (ex - bx0_r)) + 29'(ew);
        dmag = NUM_W'(bw_r) << 1;
      end
      2'd1: begin
        nsg  = 29'(2 * (bh_r - 27'(ey) + 27'(by0_r))) - 29'(eh);
        dmag = NUM_W'(bh_r) << 1;
      end
      2'd2: begin nsg = 29'(ew); dmag = NUM_W'(bw_r); end
      default: begin nsg = 29'(eh); dmag = NUM_W'(bh_r); end
    endcase
    req.neg = nsg < 0;
    req.num = NUM_W'(nsg < 0 ? -nsg : nsg);
    req.den = (step_r[0] ? bh_r : bw_r) <= 0 ? '0 : dmag;
    req.start = issue_r;
  end

  logic [6:0] total;
  assign total = tcnt_r + icnt_r;

  always_ff @(posedge clk) begin
    if (acc && (in_item_kind == KIND_TEXT || is_img) && room)
      mem[wr_idx] <= {in_pos_x, in_pos_y, in_size_w, in_size_h, is_img};
    if (state_r == S_FETCH) rd_r <= mem[ptr_r[IDX_W-1:0]];
  end

  function automatic logic [23:0] sat_s(input logic signed [26:0] v);
    if (v > 27'sd8388607) return 24'h7fffff;
    if (v < -27'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction
  function automatic logic [23:0] sat_u(input logic signed [26:0] v);
    if (v < 0) return '0;
    if (v > 27'sd16777215) return 24'hffffff;
    return v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; mode_r <= 1'b1; ph_r <= '0; lx_r <= '0; ly_r <= '0;
      lw_r <= '0; lh_r <= '0; stored_r <= '0; tcnt_r <= '0; icnt_r <= '0;
      rarea_r <= '0; iarea_r <= '0;
      ux0_r <= 26'sh1ffffff; uy0_r <= 26'sh1ffffff;
      ux1_r <= -26'sh2000000; uy1_r <= -26'sh2000000;
      out_valid <= 1'b0; issue_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      issue_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE: mode_r <= cfg_wdata[0];
          CFG_PH:   ph_r <= cfg_wdata[22:0];
          CFG_LX:   lx_r <= cfg_wdata;
          CFG_LY:   ly_r <= cfg_wdata;
          CFG_LW:   lw_r <= cfg_wdata[22:0];
          CFG_LH:   lh_r <= cfg_wdata[22:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_LOAD: if (acc) begin
          if (in_item_kind == KIND_RECT) begin
            if (area > rarea_r) begin
              rarea_r <= area; rx_r <= 26'(in_pos_x); ry_r <= 26'(in_pos_y);
              rw_r <= in_size_w; rh_r <= in_size_h;
            end
          end else if ((in_item_kind == KIND_TEXT || is_img) && room) begin
            stored_r <= stored_r + 7'd1;
            if (is_img) begin
              icnt_r <= icnt_r + 7'd1;
              if (area > iarea_r) begin
                iarea_r <= area; ix_r <= 26'(in_pos_x); iy_r <= 26'(in_pos_y);
                iw_r <= in_size_w; ih_r <= in_size_h;
              end
            end else tcnt_r <= tcnt_r + 7'd1;
            if (26'(in_pos_x) < ux0_r) ux0_r <= 26'(in_pos_x);
            if (26'(in_pos_y) < uy0_r) uy0_r <= 26'(in_pos_y);
            if (in_x1 > ux1_r) ux1_r <= in_x1;
            if (in_y1 > uy1_r) uy1_r <= in_y1;
          end
          if (in_last_item) state_r <= S_PICK;
        end
        S_PICK: begin
          st_r <= ST_OK;
          ptr_r <= '0; n_r <= '0; pass_r <= 1'b0;
          if (!mode_r) begin
            if (rarea_r != 0) begin
              bx0_r <= rx_r;
              by0_r <= 26'(ph_r) - (ry_r + 26'(rh_r));
              bw_r <= 27'(rw_r); bh_r <= 27'(rh_r);
              state_r <= total == 0 ? S_ONE : S_FETCH;
            end else if (iarea_r != 0) begin
              bx0_r <= ix_r; by0_r <= iy_r;
              bw_r <= 27'(iw_r); bh_r <= 27'(ih_r);
              state_r <= S_FETCH;
            end else begin
              st_r <= ST_NO_RECT; state_r <= S_ONE;
            end
          end else if (lw_r != 0 && lh_r != 0) begin
            bx0_r <= 26'(lx_r); by0_r <= 26'(ly_r);
            bw_r <= 27'(lw_r); bh_r <= 27'(lh_r);
            state_r <= total == 0 ? S_ONE : S_FETCH;
          end else if (total != 0) begin
            bx0_r <= ux0_r; by0_r <= uy0_r;
            bw_r <= 27'(ux1_r) - 27'(ux0_r); bh_r <= 27'(uy1_r) - 27'(uy0_r);
            state_r <= S_FETCH;
          end else begin
            st_r <= ST_NO_ELEM; state_r <= S_ONE;
          end
        end
        S_FETCH: state_r <= S_READ;
        S_READ: begin
          if (eimg != pass_r) begin
            if (ptr_r + 7'd1 >= stored_r) begin
              ptr_r <= '0; pass_r <= 1'b1;
            end else ptr_r <= ptr_r + 7'd1;
            state_r <= S_FETCH;
          end else begin
            step_r <= '0; issue_r <= 1'b1; state_r <= S_DIV;
          end
        end
        S_DIV: if (rsp.done) begin
          rel_r[step_r] <= rsp.q;
          if (step_r == 2'd3) state_r <= S_EMIT;
          else begin step_r <= step_r + 2'd1; issue_r <= 1'b1; end
        end
        S_EMIT: begin
          out_valid <= 1'b1; out_status <= ST_OK;
          out_elem_kind <= pass_r ? EK_IMAGE : EK_TEXT;
          out_rel_center_x <= rel_r[0]; out_rel_center_y <= rel_r[1];
          out_rel_width <= rel_r[2]; out_rel_height <= rel_r[3];
          out_bounds_left <= sat_s(27'(bx0_r)); out_bounds_bottom <= sat_s(27'(by0_r));
          out_bounds_width <= sat_u(bw_r); out_bounds_height <= sat_u(bh_r);
          out_last_result <= n_r + 7'd1 == total;
          n_r <= n_r + 7'd1;
          if (n_r + 7'd1 == total) state_r <= S_LOAD;
          else begin
            if (ptr_r + 7'd1 >= stored_r) begin
              ptr_r <= '0; pass_r <= 1'b1;
            end else ptr_r <= ptr_r + 7'd1;
            state_r <= S_FETCH;
          end
        end
        S_ONE: begin
          out_valid <= 1'b1; out_status <= st_r; out_elem_kind <= EK_BOUNDS;
          out_rel_center_x <= '0; out_rel_center_y <= '0;
          out_rel_width <= '0; out_rel_height <= '0;
          out_bounds_left <= st_r == ST_OK ? sat_s(27'(bx0_r)) : '0;
          out_bounds_bottom <= st_r == ST_OK ? sat_s(27'(by0_r)) : '0;
          out_bounds_width <= st_r == ST_OK ? sat_u(bw_r) : '0;
          out_bounds_height <= st_r == ST_OK ? sat_u(bh_r) : '0;
          out_last_result <= 1'b1;
          state_r <= S_LOAD;
        end
        default: state_r <= S_LOAD;
      endcase
      if ((state_r == S_EMIT && n_r + 7'd1 == total) || state_r == S_ONE) begin
        stored_r <= '0; tcnt_r <= '0; icnt_r <= '0; rarea_r <= '0; iarea_r <= '0;
        ux0_r <= 26'sh1ffffff; uy0_r <= 26'sh1ffffff;
        ux1_r <= -26'sh2000000; uy1_r <= -26'sh2000000;
      end
    end
  end
endmodule
`default_nettype wire

/* sv/rln_div.sv */
// ---------------------------------------------------------------------------
// rln_div: shared radix-2 ratio divider
// round(num * 2^14 / den) ties away from zero, sign applied, saturated Q2.14.
// ---------------------------------------------------------------------------
`default_nettype none
module rln_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rln_pkg::div_req_t req,
  output rln_pkg::div_rsp_t    rsp
);
  import rln_pkg::*;

  // dividend num*2^15 + den, divisor 2*den, 17 quotient bits retained
  localparam int D_W = NUM_W + 17;
  localparam int R_W = NUM_W + 2;

  logic             busy_r, busy_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [D_W-1:0]   dvd_r, dvd_nxt;
  logic [R_W-1:0]   rem_r, rem_nxt;
  logic [R_W-1:0]   dsr_r, dsr_nxt;
  logic [Q_W+5:0]   quo_r, quo_nxt;
  logic             neg_r, neg_nxt;
  logic             done_r, done_nxt;
  logic [15:0]      q_r, q_nxt;
  logic [R_W-1:0]   sh;
  logic [R_W:0]     diff;
  logic [Q_W+5:0]   qf;

  always_comb begin
    busy_nxt = busy_r; cnt_nxt = cnt_r; dvd_nxt = dvd_r; rem_nxt = rem_r;
    dsr_nxt = dsr_r; quo_nxt = quo_r; neg_nxt = neg_r; done_nxt = 1'b0;
    q_nxt = q_r;
    sh = {rem_r[R_W-2:0], dvd_r[D_W-1]};
    diff = {1'b0, sh} - {1'b0, dsr_r};
    qf = quo_r;
    if (req.start) begin
      if (req.den == '0) begin
        done_nxt = 1'b1;
        q_nxt = (req.num == '0) ? 16'h0000 : (req.neg ? 16'h8000 : 16'h7fff);
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        dvd_nxt  = ({17'd0, req.num} << 15) + {17'd0, req.den};
        rem_nxt  = '0;
        dsr_nxt  = {req.den, 1'b0} + R_W'(0);
        quo_nxt  = '0;
        neg_nxt  = req.neg;
      end
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (!diff[R_W]) begin
        rem_nxt = diff[R_W-1:0];
        qf = {quo_r[Q_W+4:0], 1'b1};
      end else begin
        rem_nxt = sh;
        qf = {quo_r[Q_W+4:0], 1'b0};
      end
      // saturate sticky so the quotient register stays narrow
      if (quo_r[Q_W+5] | quo_r[Q_W+4] | quo_r[Q_W+3] | quo_r[Q_W+2] |
          quo_r[Q_W+1] | quo_r[Q_W]) qf = {(Q_W+6){1'b1}};
      quo_nxt = qf;
      cnt_nxt = cnt_r + 6'd1;
    end
    if (busy_r && cnt_r == 6'(D_W - 1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
      if (qf > (Q_W+6)'(32768)) qf = (Q_W+6)'(32768);
      q_nxt = neg_r ? 16'(-qf[15:0]) : ((qf[15]) ? 16'h7fff : qf[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt; rem_r <= rem_nxt; dsr_r <= dsr_nxt;
    quo_r <= quo_nxt; neg_r <= neg_nxt; q_r <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: page-level check of the relative layout normalizer
// Sends pages of rectangle, text and image boxes under several register
// settings, predicts bounds and normalized ratios, and compares every beat.
// ---------------------------------------------------------------------------
`default_nettype none

class layout_scoreboard;
  typedef struct {
    logic [1:0]  status;
    logic [1:0]  ekind;
    logic [15:0] rel[4];
    logic [23:0] bnd[4];
    logic        last;
  } result_t;

  typedef struct {
    longint x, y, w, h;
    bit     img;
  } box_t;

  // registers
  bit     mode = 1;
  longint page_h, lb_x, lb_y, lb_w, lb_h;
  // page state
  box_t    boxes[$];
  int      n_text, n_image;
  longint  rect_area, image_area;
  box_t    rect_box, image_box;
  longint  ux0, uy0, ux1, uy1;
  result_t pending[$];
  int      errors;
  int      seen;

  function new();
    clear_page();
  endfunction

  function void clear_page();
    boxes.delete();
    n_text = 0; n_image = 0; rect_area = 0; image_area = 0;
    rect_box = '{0, 0, 0, 0, 0}; image_box = '{0, 0, 0, 0, 0};
    ux0 = 64'sh7fffffffffffffff; uy0 = ux0; ux1 = -ux0 - 1; uy1 = ux1;
  endfunction

  function void write_reg(logic [2:0] idx, logic [23:0] v);
    case (idx)
      rln_pkg::CFG_MODE: mode = v[0];
      rln_pkg::CFG_PH:   page_h = v[22:0];
      rln_pkg::CFG_LX:   lb_x = $signed(v);
      rln_pkg::CFG_LY:   lb_y = $signed(v);
      rln_pkg::CFG_LW:   lb_w = v[22:0];
      rln_pkg::CFG_LH:   lb_h = v[22:0];
      default: ;
    endcase
  endfunction

  static function longint q14(longint num, longint den);
    longint mag, q;
    if (den <= 0) return num > 0 ? 32767 : (num < 0 ? -32768 : 0);
    mag = num < 0 ? -num : num;
    q = (mag * 32768 + den) / (2 * den);
    if (q > 32768) q = 32768;
    q = num < 0 ? -q : q;
    return q > 32767 ? 32767 : q;
  endfunction

  static function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function void push(logic [1:0] st, logic [1:0] ek, longint r[4], longint b[4],
                     bit last);
    result_t e;
    e.status = st; e.ekind = ek; e.last = last;
    foreach (r[i]) e.rel[i] = r[i][15:0];
    e.bnd[0] = 24'(clip(b[0], -8388608, 8388607));
    e.bnd[1] = 24'(clip(b[1], -8388608, 8388607));
    e.bnd[2] = 24'(clip(b[2], 0, 16777215));
    e.bnd[3] = 24'(clip(b[3], 0, 16777215));
    pending.insert(pending.size(), e);
  endfunction

  function void close_page();
    longint x0, y0, x1, y1, bw, bh, r[4], b[4];
    int total, n;
    total = n_text + n_image;
    r = '{0, 0, 0, 0}; b = '{0, 0, 0, 0};
    if (mode == 0) begin
      if (rect_area > 0) begin
        x0 = rect_box.x; x1 = rect_box.x + rect_box.w;
        y0 = page_h - (rect_box.y + rect_box.h); y1 = page_h - rect_box.y;
      end else if (image_area > 0) begin
        x0 = image_box.x; y0 = image_box.y;
        x1 = x0 + image_box.w; y1 = y0 + image_box.h;
      end else begin
        push(rln_pkg::ST_NO_RECT, rln_pkg::EK_BOUNDS, r, b, 1);
        return;
      end
    end else if (lb_w > 0 && lb_h > 0) begin
      x0 = lb_x; y0 = lb_y; x1 = x0 + lb_w; y1 = y0 + lb_h;
    end else if (total > 0) begin
      x0 = ux0; y0 = uy0; x1 = ux1; y1 = uy1;
    end else begin
      push(rln_pkg::ST_NO_ELEM, rln_pkg::EK_BOUNDS, r, b, 1);
      return;
    end
    bw = x1 - x0; bh = y1 - y0;
    b = '{x0, y0, bw, bh};
    if (total == 0) begin
      push(rln_pkg::ST_OK, rln_pkg::EK_BOUNDS, r, b, 1);
      return;
    end
    n = 0;
    for (int p = 0; p < 2; p++)
      foreach (boxes[i]) begin
        if (boxes[i].img != p) continue;
        r[0] = q14(2 * (boxes[i].x - x0) + boxes[i].w, 2 * bw);
        r[1] = q14(2 * (bh - boxes[i].y + y0) - boxes[i].h, 2 * bh);
        r[2] = q14(boxes[i].w, bw);
        r[3] = q14(boxes[i].h, bh);
        push(rln_pkg::ST_OK, p ? rln_pkg::EK_IMAGE : rln_pkg::EK_TEXT, r, b,
             n == total - 1);
        n++;
      end
  endfunction

  function void note_item(logic [1:0] kind, logic [23:0] px, logic [23:0] py,
                          logic [22:0] sw, logic [22:0] sh, logic last);
    box_t bx;
    longint area;
    bit room;
    bx.x = $signed(px); bx.y = $signed(py); bx.w = sw; bx.h = sh; bx.img = 0;
    area = bx.w * bx.h;
    if (kind == rln_pkg::KIND_RECT) begin
      if (area > rect_area) begin
        rect_area = area; rect_box = bx;
      end
    end else if (kind == rln_pkg::KIND_TEXT || kind == rln_pkg::KIND_IMAGE) begin
      bx.img = (kind == rln_pkg::KIND_IMAGE);
      room = boxes.size() < rln_pkg::DEPTH && (bx.img ? n_image < 32 : n_text < 32);
      if (room) begin
        boxes.insert(boxes.size(), bx);
        if (bx.img) begin
          n_image++;
          if (area > image_area) begin
            image_area = area; image_box = bx;
          end
        end else n_text++;
        if (bx.x < ux0) ux0 = bx.x;
        if (bx.y < uy0) uy0 = bx.y;
        if (bx.x + bx.w > ux1) ux1 = bx.x + bx.w;
        if (bx.y + bx.h > uy1) uy1 = bx.y + bx.h;
      end
    end
    if (last) begin
      close_page();
      clear_page();
    end
  endfunction

  function void check_result(logic [1:0] st, logic [1:0] ek, logic [15:0] r[4],
                             logic [23:0] b[4], logic last);
    result_t e;
    seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result beat, status %0d kind %0d", $time, st, ek);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (st !== e.status) begin
      $display("%0t: status exp %0d got %0d", $time, e.status, st); errors++;
    end
    if (ek !== e.ekind) begin
      $display("%0t: elem_kind exp %0d got %0d", $time, e.ekind, ek); errors++;
    end
    foreach (r[i])
      if (r[i] !== e.rel[i]) begin
        $display("%0t: ratio %0d exp %h got %h", $time, i, e.rel[i], r[i]); errors++;
      end
    foreach (b[i])
      if (b[i] !== e.bnd[i]) begin
        $display("%0t: bounds %0d exp %h got %h", $time, i, e.bnd[i], b[i]); errors++;
      end
    if (last !== e.last) begin
      $display("%0t: last_result exp %0d got %0d", $time, e.last, last); errors++;
    end
  endfunction
endclass

module tb_top;
  import rln_pkg::*;

  localparam logic [1:0] KIND_BAD = 2'd3;

  logic clk, rst_n, start, busy;
  logic [1:0]  in_item_kind;
  logic signed [23:0] in_pos_x, in_pos_y;
  logic [22:0] in_size_w, in_size_h;
  logic in_last_item, cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;
  logic out_valid, out_last_result;
  logic [1:0] out_status, out_elem_kind;
  logic signed [15:0] out_rel_center_x, out_rel_center_y, out_rel_width, out_rel_height;
  logic signed [23:0] out_bounds_left, out_bounds_bottom;
  logic [23:0] out_bounds_width, out_bounds_height;

  relative_layout_normalizer dut (.*);

  layout_scoreboard sb = new();
  int  sent;
  bit  calm;
  int  idle_cycles;
  // longest quiet stretch: one result plus skipped entries,
  // or the settle
  localparam int WATCHDOG = 5000;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_elem_kind,
                      '{out_rel_center_x, out_rel_center_y, out_rel_width, out_rel_height},
                      '{out_bounds_left, out_bounds_bottom, out_bounds_width,
                        out_bounds_height}, out_last_result);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic set_reg(logic [2:0] idx, logic [23:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // start stays high after the beat; the next send or settle takes it over
  task automatic send(logic [1:0] k, logic [23:0] px, logic [23:0] py,
                      logic [22:0] w, logic [22:0] h, logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1; in_item_kind <= k; in_pos_x <= px; in_pos_y <= py;
    in_size_w <= w; in_size_h <= h; in_last_item <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(k, px, py, w, h, last);
    sent++;
  endtask

  function automatic logic [23:0] rnd24(bit wide);
    return wide ? 24'($urandom) : 24'($signed($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic logic [22:0] rnd23(bit wide);
    case ($urandom_range(0, 5))
      0: return 23'd0;
      1: return 23'($urandom);
      default: return wide ? 23'($urandom) : 23'($urandom_range(1, 3000));
    endcase
  endfunction

  task automatic rand_page(int n);
    bit wide;
    logic [1:0] k;
    wide = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9) == 0 ? KIND_BAD : 2'($urandom_range(0, 2));
      send(k, rnd24(wide), rnd24(wide), rnd23(wide), rnd23(wide), i == n - 1);
    end
  endtask

  initial begin
    rst_n = 0; start = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    in_item_kind = 0; in_pos_x = 0; in_pos_y = 0; in_size_w = 0; in_size_h = 0;
    in_last_item = 0; sent = 0; calm = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // union mode at reset: empty page, then extremes
    send(KIND_RECT, 0, 0, 5, 5, 1);
    send(KIND_TEXT, 24'h800000, 24'h800000, 23'h7fffff, 23'h7fffff, 0);
    send(KIND_IMAGE, 24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff, 0);
    send(KIND_BAD, 1, 1, 1, 1, 1);
    send(KIND_TEXT, 100, 200, 0, 0, 1);        // zero-size bounds, zero ratios
    send(KIND_IMAGE, -24'sd50, 10, 0, 40, 1);
    settle();
    set_reg(CFG_MODE, 0);
    set_reg(CFG_PH, 23'h7fffff);
    send(KIND_TEXT, 10, 10, 20, 20, 1);        // no rectangle or image
    send(KIND_RECT, 0, 1000, 100, 50, 0);
    send(KIND_RECT, 5, 900, 50, 100, 0);       // tie, first wins
    send(KIND_RECT, 5, 900, 0, 900, 0);
    send(KIND_TEXT, 20, 8388000, 30, 10, 1);
    send(KIND_IMAGE, 0, 0, 80, 80, 0);         // image fallback
    send(KIND_TEXT, 10, 10, 8, 8, 1);
    send(KIND_RECT, 0, 0, 10, 10, 1);          // bounds only
    // store full: 40 texts, 40 images
    for (int i = 0; i < 80; i++)
      send(i < 40 ? KIND_TEXT : KIND_IMAGE, 24'(i * 7), 24'(i * 3), 23'(i + 1), 9, i == 79);
    settle();
    set_reg(CFG_MODE, 1);
    set_reg(CFG_LX, 24'h800000); set_reg(CFG_LY, 24'h7fffff);
    set_reg(CFG_LW, 23'h7fffff); set_reg(CFG_LH, 23'h7fffff);
    send(KIND_TEXT, 0, 0, 100, 100, 1);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin set_reg(CFG_LX, 0); set_reg(CFG_LY, 0); set_reg(CFG_LW, 2000);
             set_reg(CFG_LH, 0); end
        1: begin set_reg(CFG_LX, 24'($signed(-1000))); set_reg(CFG_LY, 24'($signed(-1000)));
             set_reg(CFG_LW, 3000); set_reg(CFG_LH, 3000); end
        2: begin set_reg(CFG_MODE, 0); set_reg(CFG_PH, 0); end
        3: set_reg(CFG_PH, 24'($urandom_range(0, 5000)));
        4: begin set_reg(CFG_MODE, 1); set_reg(CFG_LW, 0); end
        5: begin set_reg(CFG_MODE, 24'($urandom_range(0, 1))); calm = 1; end
      endcase
      while (sent < 115 + (ph + 1) * 52) rand_page($urandom_range(1, 12));
    end

    settle();
    if (sb.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
`default_nettype wire
